### hw/rtl/msp_pkg.sv
// Shared types and constants of the motion sequence player.
package msp_pkg;

    localparam int FINGER_W   = 8;
    localparam int HOLD_W     = 16;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;
    localparam int REPEAT_W   = 8;
    localparam int MOTION_W   = 5 * FINGER_W + HOLD_W;
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 48;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_START = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    // One stored motion as it sits in the table.
    typedef struct packed {
        logic [HOLD_W-1:0]   hold;
        logic [FINGER_W-1:0] thumb;
        logic [FINGER_W-1:0] little;
        logic [FINGER_W-1:0] ring;
        logic [FINGER_W-1:0] middle;
        logic [FINGER_W-1:0] pointer;
    } motion_t;

    // Decoded input request.
    typedef struct packed {
        logic [1:0]          operation;
        logic [SLOT_W-1:0]   entry_index;
        motion_t             motion;
        logic [COUNT_W-1:0]  motion_count;
        logic                loop_forever;
        logic [REPEAT_W-1:0] repeat_count;
    } in_item_t;

    // One emitted motion.
    typedef struct packed {
        logic [FINGER_W-1:0] pointer_pos;
        logic [FINGER_W-1:0] middle_pos;
        logic [FINGER_W-1:0] ring_pos;
        logic [FINGER_W-1:0] little_pos;
        logic [FINGER_W-1:0] thumb_pos;
        logic [SLOT_W-1:0]   motion_slot;
        logic                gesture_done;
    } result_t;

endpackage

### hw/rtl/motion_sequence_player.sv
// Top level of the motion sequence player: stream ports, output register and motion table.
//
//  channel  | direction | tuser          | tlast        | tdata
//  s_       | in        | operation      | -            | write entry and start fields
//  m_       | out       | -              | gesture_done | finger positions and slot
//
// Write, start and ticks that emit nothing are done in the idle state. A tick that emits
// a motion also passes through the fetch state, as the motion table is read through its
// registered read port; it stays there while the output register holds an untaken result.
// A new request is accepted while a finished result waits in the output register.
// Reset clears the playback state only; the motion table is not cleared.
module motion_sequence_player #(
    parameter int MAX_MOTIONS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index, pointer_in, middle_in, ring_in, little_in, thumb_in, hold_ticks,
    // motion_count, loop_forever, repeat_count, zero fill
    input  logic [msp_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pointer_pos, middle_pos, ring_pos, little_pos, thumb_pos, motion_slot, zero fill
    output logic [msp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import msp_pkg::*;

    localparam int IDX_W = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;

    in_item_t         item;
    result_t          result;
    result_t          out_reg;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             in_accept;
    logic             out_free;
    logic             out_load;
    logic             ram_wr_en;
    logic [IDX_W-1:0] ram_wr_addr;
    motion_t          ram_wr_data;
    logic             ram_rd_en;
    logic [IDX_W-1:0] ram_rd_addr;
    motion_t          ram_rd_data;

    assign item.operation      = s_tuser;
    assign item.entry_index    = s_tdata[5:0];
    assign item.motion.pointer = s_tdata[13:6];
    assign item.motion.middle  = s_tdata[21:14];
    assign item.motion.ring    = s_tdata[29:22];
    assign item.motion.little  = s_tdata[37:30];
    assign item.motion.thumb   = s_tdata[45:38];
    assign item.motion.hold    = s_tdata[61:46];
    assign item.motion_count   = s_tdata[68:62];
    assign item.loop_forever   = s_tdata[69];
    assign item.repeat_count   = s_tdata[77:70];

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    msp_ctrl #(
        .MAX_MOTIONS (MAX_MOTIONS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_item     (item),
        .in_ready    (s_tready),
        .out_free    (out_free),
        .out_load    (out_load),
        .out_result  (result),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    msp_ram #(
        .WIDTH (MOTION_W),
        .DEPTH (MAX_MOTIONS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.motion_slot, out_reg.thumb_pos, out_reg.little_pos,
                       out_reg.ring_pos, out_reg.middle_pos, out_reg.pointer_pos};
    assign m_tlast  = out_reg.gesture_done;
endmodule

### hw/rtl/msp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module msp_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 64
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### hw/rtl/msp_ctrl.sv
// Playback sequencer: gesture state, tick countdown and motion table access.
module msp_ctrl #(
    parameter int MAX_MOTIONS = 64
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  in_accept,
    input  msp_pkg::in_item_t                                     in_item,
    output logic                                                  in_ready,
    input  logic                                                  out_free,
    output logic                                                  out_load,
    output msp_pkg::result_t                                      out_result,
    output logic                                                  ram_wr_en,
    output logic [(MAX_MOTIONS > 1 ? $clog2(MAX_MOTIONS) : 1)-1:0] ram_wr_addr,
    output msp_pkg::motion_t                                      ram_wr_data,
    output logic                                                  ram_rd_en,
    output logic [(MAX_MOTIONS > 1 ? $clog2(MAX_MOTIONS) : 1)-1:0] ram_rd_addr,
    input  msp_pkg::motion_t                                      ram_rd_data
);
    import msp_pkg::*;

    localparam int IDX_W = (MAX_MOTIONS > 1) ? $clog2(MAX_MOTIONS) : 1;
    localparam int CNT_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MOTIONS);

    state_t              state_reg, state_next;
    logic                playing_reg, playing_next;
    logic [IDX_W-1:0]    play_index_reg, play_index_next;
    logic [REPEAT_W-1:0] repeat_done_reg, repeat_done_next;
    logic [HOLD_W-1:0]   wait_count_reg, wait_count_next;
    logic [CNT_W-1:0]    length_reg, length_next;
    logic                loops_reg, loops_next;
    logic [REPEAT_W-1:0] repeats_reg, repeats_next;

    logic [CNT_W-1:0]    entry_ext;
    logic [CNT_W-1:0]    count_ext;
    logic [CNT_W-1:0]    index_ext;
    logic [CNT_W-1:0]    index_inc;
    logic [HOLD_W-1:0]   wait_dec;
    logic [REPEAT_W:0]   repeat_inc;

    assign entry_ext  = CNT_W'(in_item.entry_index);
    assign count_ext  = CNT_W'(in_item.motion_count);
    assign index_ext  = CNT_W'(play_index_reg);
    assign index_inc  = index_ext + CNT_W'(1);
    assign wait_dec   = (wait_count_reg != '0) ? wait_count_reg - HOLD_W'(1) : '0;
    assign repeat_inc = {1'b0, repeat_done_reg} + (REPEAT_W + 1)'(1);

    assign ram_wr_addr = entry_ext[IDX_W-1:0];
    assign ram_wr_data = in_item.motion;
    assign ram_rd_addr = play_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            playing_reg     <= 1'b0;
            play_index_reg  <= '0;
            repeat_done_reg <= '0;
            wait_count_reg  <= '0;
            length_reg      <= '0;
            loops_reg       <= 1'b0;
            repeats_reg     <= REPEAT_W'(1);
        end else begin
            state_reg       <= state_next;
            playing_reg     <= playing_next;
            play_index_reg  <= play_index_next;
            repeat_done_reg <= repeat_done_next;
            wait_count_reg  <= wait_count_next;
            length_reg      <= length_next;
            loops_reg       <= loops_next;
            repeats_reg     <= repeats_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        playing_next     = playing_reg;
        play_index_next  = play_index_reg;
        repeat_done_next = repeat_done_reg;
        wait_count_next  = wait_count_reg;
        length_next      = length_reg;
        loops_next       = loops_reg;
        repeats_next     = repeats_reg;
        in_ready         = 1'b0;
        out_load         = 1'b0;
        ram_wr_en        = 1'b0;
        ram_rd_en        = 1'b0;

        out_result.pointer_pos  = ram_rd_data.pointer;
        out_result.middle_pos   = ram_rd_data.middle;
        out_result.ring_pos     = ram_rd_data.ring;
        out_result.little_pos   = ram_rd_data.little;
        out_result.thumb_pos    = ram_rd_data.thumb;
        out_result.motion_slot  = index_ext[SLOT_W-1:0];
        out_result.gesture_done = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_accept) begin
                    case (in_item.operation)
                        OP_WRITE: begin
                            ram_wr_en = (entry_ext < MAX_CNT);
                        end
                        OP_START: begin
                            if (in_item.motion_count != '0) begin
                                length_next      = (count_ext > MAX_CNT) ? MAX_CNT : count_ext;
                                loops_next       = in_item.loop_forever;
                                repeats_next     = (in_item.repeat_count == '0) ?
                                                   REPEAT_W'(1) : in_item.repeat_count;
                                play_index_next  = '0;
                                wait_count_next  = '0;
                                repeat_done_next = '0;
                                playing_next     = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (playing_reg) begin
                                wait_count_next = wait_dec;
                                // The motion is due: read it and finish in the fetch state.
                                if (wait_dec == '0) begin
                                    ram_rd_en  = 1'b1;
                                    state_next = ST_FETCH;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                // The read data stays in the RAM register until the output stage is free.
                if (out_free) begin
                    out_load        = 1'b1;
                    state_next      = ST_IDLE;
                    wait_count_next = ram_rd_data.hold;
                    if (index_inc >= length_reg) begin
                        if (loops_reg) begin
                            play_index_next = '0;
                        end else if (repeat_inc < {1'b0, repeats_reg}) begin
                            play_index_next  = '0;
                            repeat_done_next = repeat_inc[REPEAT_W-1:0];
                        end else begin
                            playing_next            = 1'b0;
                            play_index_next         = '0;
                            repeat_done_next        = '0;
                            wait_count_next         = '0;
                            out_result.gesture_done = 1'b1;
                        end
                    end else begin
                        play_index_next = index_inc[IDX_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

### verif/motion_sequence_player_test.sv
// Self-checking testbench of the motion sequence player with its own playback predictor.
module motion_sequence_player_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msp_pkg::*;

    localparam real        CLK_PERIOD    = 10.0;
    localparam int         MOTION_SLOTS  = 64;
    localparam int         RANDOM_ITEMS  = 1150;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         REPORT_LIMIT  = 10;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_CHOKED
    } rx_mode_t;

    // One request of the directed table or of the random part. Rows marked fixed carry
    // their result typed in; all others are checked against the predictor.
    typedef struct {
        in_item_t req;
        bit       fixed;
        bit       fixed_has;
        result_t  fixed_res;
    } stim_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // Predictor state.
    motion_t     motion_store [MOTION_SLOTS];
    bit          gest_playing = 1'b0;
    int          play_pos     = 0;
    int          reps_done    = 0;
    logic [15:0] hold_left    = '0;
    int          gest_len     = 0;
    bit          gest_loop    = 1'b0;
    int          gest_reps    = 1;

    result_t expected_motions [$];
    int      mismatches   = 0;
    int      items_sent   = 0;
    int      burst_left   = 0;
    int      quiet_cycles = 0;

    rx_mode_t rx_mode  = RX_OPEN;
    int       rx_left  = 0;
    int       rx_cycle = 0;

    motion_sequence_player #(
        .MAX_MOTIONS(MOTION_SLOTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // Advances the predicted playback by one request; returns 1 when a motion is emitted.
    function automatic bit play_step(input in_item_t req, output result_t res);
        motion_t m;
        res = '0;
        if (req.operation == OP_WRITE) begin
            motion_store[req.entry_index] = req.motion;
            return 1'b0;
        end
        if (req.operation == OP_START) begin
            if (req.motion_count == 0)
                return 1'b0;
            gest_len     = (req.motion_count > MOTION_SLOTS) ? MOTION_SLOTS
                                                             : int'(req.motion_count);
            gest_loop    = req.loop_forever;
            gest_reps    = (req.repeat_count == 0) ? 1 : int'(req.repeat_count);
            play_pos     = 0;
            hold_left    = '0;
            reps_done    = 0;
            gest_playing = 1'b1;
            return 1'b0;
        end
        if (req.operation != OP_TICK || !gest_playing)
            return 1'b0;
        if (hold_left != 0)
            hold_left = hold_left - 16'd1;
        if (hold_left != 0)
            return 1'b0;

        m = motion_store[play_pos];
        res.pointer_pos  = m.pointer;
        res.middle_pos   = m.middle;
        res.ring_pos     = m.ring;
        res.little_pos   = m.little;
        res.thumb_pos    = m.thumb;
        res.motion_slot  = 6'(play_pos);
        res.gesture_done = 1'b0;
        hold_left        = m.hold;
        play_pos         = play_pos + 1;
        if (play_pos >= gest_len) begin
            if (gest_loop) begin
                play_pos = 0;
            end else if (reps_done + 1 < gest_reps) begin
                play_pos  = 0;
                reps_done = reps_done + 1;
            end else begin
                gest_playing     = 1'b0;
                play_pos         = 0;
                reps_done        = 0;
                hold_left        = '0;
                res.gesture_done = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // Random contents everywhere; the caller then sets the fields that matter.
    function automatic in_item_t noise_req(input logic [1:0] op);
        logic [95:0] bits;
        in_item_t    req;
        bits          = {$urandom, $urandom, $urandom};
        req           = bits[79:0];
        req.operation = op;
        return req;
    endfunction

    function automatic in_item_t tick_req();
        return noise_req(OP_TICK);
    endfunction

    function automatic in_item_t write_req(input logic [5:0] slot, input motion_t m);
        in_item_t req;
        req             = noise_req(OP_WRITE);
        req.entry_index = slot;
        req.motion      = m;
        return req;
    endfunction

    function automatic in_item_t start_req(input logic [6:0] count, input logic loop,
                                           input logic [7:0] reps);
        in_item_t req;
        req              = noise_req(OP_START);
        req.motion_count = count;
        req.loop_forever = loop;
        req.repeat_count = reps;
        return req;
    endfunction

    function automatic motion_t motion_of(input logic [7:0] p, input logic [7:0] mid,
                                          input logic [7:0] r, input logic [7:0] l,
                                          input logic [7:0] t, input logic [15:0] hold);
        motion_t m;
        m.pointer = p;
        m.middle  = mid;
        m.ring    = r;
        m.little  = l;
        m.thumb   = t;
        m.hold    = hold;
        return m;
    endfunction

    function automatic motion_t rand_motion();
        int pick;
        motion_t m;
        m.pointer = 8'($urandom_range(0, 255));
        m.middle  = 8'($urandom_range(0, 255));
        m.ring    = 8'($urandom_range(0, 255));
        m.little  = 8'($urandom_range(0, 255));
        m.thumb   = 8'($urandom_range(0, 255));
        pick      = $urandom_range(0, 99);
        // Mostly short holds so that gestures keep moving; now and then a very long one.
        if (pick < 65)
            m.hold = 16'($urandom_range(0, 2));
        else if (pick < 90)
            m.hold = 16'($urandom_range(3, 12));
        else if (pick < 97)
            m.hold = 16'($urandom_range(13, 300));
        else
            m.hold = 16'($urandom_range(0, 65535));
        return m;
    endfunction

    function automatic result_t motion_res(input logic [7:0] p, input logic [7:0] mid,
                                           input logic [7:0] r, input logic [7:0] l,
                                           input logic [7:0] t, input logic [5:0] slot,
                                           input logic done);
        result_t res;
        res.pointer_pos  = p;
        res.middle_pos   = mid;
        res.ring_pos     = r;
        res.little_pos   = l;
        res.thumb_pos    = t;
        res.motion_slot  = slot;
        res.gesture_done = done;
        return res;
    endfunction

    function automatic stim_row_t row_of(input in_item_t req);
        stim_row_t row;
        row.req       = req;
        row.fixed     = 1'b0;
        row.fixed_has = 1'b0;
        row.fixed_res = '0;
        return row;
    endfunction

    function automatic stim_row_t row_fixed(input in_item_t req, input bit has,
                                            input result_t res);
        stim_row_t row;
        row.req       = req;
        row.fixed     = 1'b1;
        row.fixed_has = has;
        row.fixed_res = res;
        return row;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("fingers %h %h %h %h %h slot %0d done %b", r.pointer_pos,
                         r.middle_pos, r.ring_pos, r.little_pos, r.thumb_pos,
                         r.motion_slot, r.gesture_done);
    endfunction

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s: expected %s, got %s", $realtime, what, show(want), show(got));
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_row(input stim_row_t row);
        result_t res;
        bit      has;
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 16);
        end
        s_tvalid = 1'b1;
        s_tuser  = row.req.operation;
        // Fields from the highest bit down, with two bits of zero fill on top.
        s_tdata  = {2'b00, row.req.repeat_count, row.req.loop_forever, row.req.motion_count,
                    row.req.motion, row.req.entry_index};
        do @(posedge aclk); while (!s_tready);
        has = play_step(row.req, res);
        if (row.fixed) begin
            has = row.fixed_has;
            res = row.fixed_res;
        end
        if (has)
            expected_motions.push_back(res);
        if (row.req.operation != OP_UNUSED)
            items_sent++;
        burst_left--;
        @(negedge aclk);
    endtask

    // Holds the sender off until every predicted motion has come out.
    task automatic drain();
        s_tvalid   = 1'b0;
        burst_left = 0;
        while (expected_motions.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(10, 80);
        end
        rx_left--;
        rx_cycle++;
        case (rx_mode)
            RX_OPEN:   m_tready = 1'b1;
            RX_RANDOM: m_tready = 1'($urandom_range(0, 1));
            default:   m_tready = (rx_cycle % 5 == 0);
        endcase
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pointer_pos  = m_tdata[7:0];
            got.middle_pos   = m_tdata[15:8];
            got.ring_pos     = m_tdata[23:16];
            got.little_pos   = m_tdata[31:24];
            got.thumb_pos    = m_tdata[39:32];
            got.motion_slot  = m_tdata[45:40];
            got.gesture_done = m_tlast;
            if (expected_motions.size() == 0) begin
                note_mismatch("motion with none expected", '0, got);
            end else begin
                want = expected_motions.pop_front();
                if (got !== want)
                    note_mismatch("wrong motion", want, got);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t   directed [$];
        int          random_base;
        int          n_ticks;
        int          pick;
        logic [6:0]  count;
        logic [7:0]  reps;

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Idle ticks and an empty gesture give nothing.
        directed.push_back(row_fixed(tick_req(), 1'b0, '0));
        directed.push_back(row_of(start_req(7'd0, 1'b0, 8'd5)));
        directed.push_back(row_fixed(tick_req(), 1'b0, '0));
        directed.push_back(row_of(write_req(6'd0,
            motion_of(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0))));
        directed.push_back(row_of(write_req(6'd1,
            motion_of(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd1))));
        directed.push_back(row_of(write_req(6'd2,
            motion_of(8'h01, 8'h80, 8'h7F, 8'hFE, 8'h5A, 16'd2))));
        directed.push_back(row_of(write_req(6'd3,
            motion_of(8'hC3, 8'h3C, 8'h96, 8'h69, 8'hA5, 16'hFFFF))));
        directed.push_back(row_of(noise_req(OP_UNUSED)));
        // Repeat count zero plays the gesture once.
        directed.push_back(row_of(start_req(7'd2, 1'b0, 8'd0)));
        directed.push_back(row_fixed(tick_req(), 1'b1,
            motion_res(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6'd0, 1'b0)));
        directed.push_back(row_fixed(tick_req(), 1'b1,
            motion_res(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 6'd1, 1'b1)));
        directed.push_back(row_fixed(tick_req(), 1'b0, '0));
        directed.push_back(row_of(start_req(7'd3, 1'b0, 8'd2)));
        repeat (5) directed.push_back(row_of(tick_req()));
        // A looping gesture replaces the one playing and ends on the longest hold.
        directed.push_back(row_of(start_req(7'd4, 1'b1, 8'd255)));
        repeat (6) directed.push_back(row_of(tick_req()));
        directed.push_back(row_of(write_req(6'd0,
            motion_of(8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 16'd0))));
        directed.push_back(row_of(start_req(7'd1, 1'b0, 8'd1)));
        directed.push_back(row_of(tick_req()));
        foreach (directed[i])
            send_row(directed[i]);
        drain();

        random_base = items_sent;
        // Fill the whole table first, so that every gesture plays written motions only.
        for (int slot = 0; slot < MOTION_SLOTS; slot++)
            send_row(row_of(write_req(6'(slot), rand_motion())));

        while (items_sent < random_base + RANDOM_ITEMS) begin
            repeat ($urandom_range(0, 3))
                send_row(row_of(write_req(6'($urandom_range(0, 63)), rand_motion())));

            pick = $urandom_range(0, 99);
            if (pick < 75)
                count = 7'($urandom_range(1, 6));
            else if (pick < 90)
                count = 7'($urandom_range(7, 64));
            else
                count = 7'($urandom_range(65, 127));
            pick = $urandom_range(0, 99);
            if (pick < 55)
                reps = 8'($urandom_range(0, 3));
            else if (pick < 85)
                reps = 8'($urandom_range(4, 12));
            else
                reps = 8'($urandom_range(0, 255));
            send_row(row_of(start_req(count, 1'($urandom_range(0, 7) == 0), reps)));

            n_ticks = $urandom_range(3, 40);
            repeat (n_ticks) begin
                pick = $urandom_range(0, 23);
                if (pick == 0)
                    send_row(row_of(noise_req(OP_UNUSED)));
                else if (pick == 1)
                    send_row(row_of(write_req(6'($urandom_range(0, 63)), rand_motion())));
                else if (pick == 2)
                    send_row(row_of(start_req(7'd0, 1'($urandom_range(0, 1)),
                                              8'($urandom_range(0, 255)))));
                else
                    send_row(row_of(tick_req()));
            end
            if ($urandom_range(0, 5) == 0)
                drain();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_motions.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/msp_pkg.sv
hw/rtl/msp_ram.sv
hw/rtl/msp_ctrl.sv
hw/rtl/motion_sequence_player.sv
verif/motion_sequence_player_test.sv
